[rtl/ssc_pkg.sv]
`timescale 1ns / 1ps
// shared widths, defaults and the round/saturate helper for the sphere contact pipeline
// no dependencies
package ssc_pkg;

	localparam int STEPS_DEF = 2;

	// square root: 64 bit radicand, 32 bit root
	localparam int SQ_IN_W   = 64;
	localparam int SQ_ROOT_W = 32;
	localparam int SQ_REM_W  = 34;

	// contact divider: 63 bit magnitude by 32 bit radius sum
	localparam int CN_W = 63;
	localparam int CQ_W = 32;
	localparam int CD_W = 32;

	// normal divider: 65 bit magnitude by 33 bit distance
	localparam int NN_W = 65;
	localparam int NQ_W = 34;
	localparam int ND_W = 33;

	// round to nearest, tie away from zero, then saturate to signed 32 bit
	function automatic logic [31:0] round_sat(input logic neg, input logic [33:0] q,
			input logic [32:0] r, input logic [32:0] dv);
		logic        up;
		logic [34:0] q1;
		logic [31:0] res;
		up = {r, 1'b0} >= {1'b0, dv};
		q1 = {1'b0, q} + {34'd0, up};
		if (neg) begin
			if (q1 >= 35'h080000000) res = 32'h80000000;
			else res = 32'd0 - q1[31:0];
		end else begin
			if (q1 > 35'h07FFFFFFF) res = 32'h7FFFFFFF;
			else res = q1[31:0];
		end
		return res;
	endfunction

endpackage

[rtl/sphere_sphere_contact.sv]
`timescale 1ns / 1ps
// sphere pair contact test: front stages, square root and contact dividers, then rounding,
// penetration and normal product stages, normal dividers and output register; two bits
// per stage by default; throughput one transaction per cycle while the output is not
// stalled, set by the fully pipelined square root and dividers; an output stall holds the
// whole pipe in place, nothing is dropped or repeated; arst_n clears only the stage valid
// bits; datapath registers are not reset; depends on ssc_pkg, ssc_delay, ssc_sqrt, ssc_div
module sphere_sphere_contact
	import ssc_pkg::*;
#(
	parameter int STEPS = STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// center_a_x, center_a_y, center_a_z, center_b_x, center_b_y, center_b_z,
	// radius_a, radius_b, two zero pad bits
	input  logic [255:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// contact_x, contact_y, contact_z, normal_x, normal_y, normal_z
	output logic [191:0] m_axis_tdata,
	// hit, coincident
	output logic [1:0]   m_axis_tuser
);

	// stage bookkeeping: sqrt and contact divider both produce 32 bit results
	localparam int SQ_ST = (SQ_ROOT_W + STEPS - 1) / STEPS;
	localparam int ND_ST = (NQ_W + STEPS - 1) / STEPS;
	localparam int MID   = 4 + SQ_ST;          // stage holding sqrt and contact quotients
	localparam int ENDQ  = MID + 3 + ND_ST;    // stage holding normal quotients
	localparam int LAT   = ENDQ + 1;           // output register stage

	logic en;
	logic [LAT-1:0] vld_q;

	// whole pipe advances unless the output register holds an untaken result
	assign en            = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	// input unpack
	logic signed [31:0] ca [3];
	logic signed [31:0] cb [3];
	logic [30:0]        ra;
	logic [30:0]        rb;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ca[i] = s_axis_tdata[32*i +: 32];
			cb[i] = s_axis_tdata[96 + 32*i +: 32];
		end
	end
	assign ra = s_axis_tdata[222:192];
	assign rb = s_axis_tdata[253:223];

	// stage 1: center deltas, weighted products, radius sum
	logic signed [32:0] d_s1    [3];
	logic signed [63:0] pa_s1   [3];
	logic signed [63:0] pb_s1   [3];
	logic [31:0]        rsum_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= {cb[i][31], cb[i]} - {ca[i][31], ca[i]};
				pa_s1[i] <= $signed({1'b0, rb}) * ca[i];
				pb_s1[i] <= $signed({1'b0, ra}) * cb[i];
			end
			rsum_s1 <= {1'b0, ra} + {1'b0, rb};
		end
	end

	// stage 2: delta magnitudes, weighted sums, radius sum squared
	logic [32:0]        dabs    [3];
	logic [32:0]        dmag_s2 [3];
	logic [2:0]         dneg_s2;
	logic signed [63:0] num_s2  [3];
	logic [31:0]        rsum_s2;
	logic [63:0]        r2_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dabs[i] = d_s1[i][32] ? (33'd0 - $unsigned(d_s1[i])) : $unsigned(d_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dmag_s2[i] <= dabs[i];
				dneg_s2[i] <= d_s1[i][32];
				num_s2[i]  <= pa_s1[i] + pb_s1[i];
			end
			rsum_s2 <= rsum_s1;
			r2_s2   <= {32'd0, rsum_s1} * {32'd0, rsum_s1};
		end
	end

	// stage 3: squared deltas, contact numerator magnitude and sign
	logic [63:0] nabs    [3];
	logic [63:0] sq_s3   [3];
	logic [62:0] cmag_s3 [3];
	logic [2:0]  cneg_s3;
	logic [31:0] rsum_s3;
	logic [63:0] r2_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nabs[i] = num_s2[i][63] ? (64'd0 - $unsigned(num_s2[i])) : $unsigned(num_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i]   <= {31'd0, dmag_s2[i]} * {31'd0, dmag_s2[i]};
				cmag_s3[i] <= nabs[i][62:0];
				cneg_s3[i] <= num_s2[i][63];
			end
			rsum_s3 <= rsum_s2;
			r2_s3   <= r2_s2;
		end
	end

	// stage 4: squared center distance at full width
	logic [65:0] ssum_s4;
	logic [63:0] r2_s4;
	logic [62:0] cmag_s4 [3];
	logic [2:0]  cneg_s4;
	logic [31:0] rsum_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ssum_s4 <= {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};
			r2_s4   <= r2_s3;
			cmag_s4 <= cmag_s3;
			cneg_s4 <= cneg_s3;
			rsum_s4 <= rsum_s3;
		end
	end

	// stage 5: exact overlap test and coincident centers
	logic hit_s5;
	logic coin_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s5  <= ssum_s4 < {2'b00, r2_s4};
			coin_s5 <= ssum_s4 == '0;
		end
	end

	// distance square root; on a hit the sum fits in 64 bits
	logic [SQ_ROOT_W-1:0] root_m;
	logic [SQ_REM_W-1:0]  srem_m;

	ssc_sqrt #(.STEPS(STEPS)) u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (ssum_s4[SQ_IN_W-1:0]),
		.root     (root_m),
		.rem      (srem_m)
	);

	// contact point dividers, one per axis
	logic [CQ_W-1:0] cq_m  [3];
	logic [CD_W-1:0] cr_m  [3];
	logic [CD_W-1:0] cdv_m [3];

	for (genvar i = 0; i < 3; i++) begin : g_cdiv
		ssc_div #(.N(CN_W), .Q(CQ_W), .W(CD_W), .STEPS(STEPS)) u_div (
			.clk      (clk),
			.en       (en),
			.dividend (cmag_s4[i]),
			.divisor  (rsum_s4),
			.quot     (cq_m[i]),
			.rem      (cr_m[i]),
			.dv       (cdv_m[i])
		);
	end

	logic [2:0] cneg_m;

	ssc_delay #(.W(3), .D(SQ_ST)) u_dly_cneg (
		.clk (clk), .en (en), .din (cneg_s4), .dout (cneg_m)
	);

	// rounded distance and rounded contact point
	logic [32:0] dist_s21;
	logic [31:0] ct_s21 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s21 <= {1'b0, root_m} + {32'd0, (srem_m > {2'b00, root_m})};
			for (int i = 0; i < 3; i++) begin
				ct_s21[i] <= round_sat(cneg_m[i], {2'b00, cq_m[i]}, {1'b0, cr_m[i]},
					{1'b0, cdv_m[i]});
			end
		end
	end

	logic [31:0] rsum_m1;

	ssc_delay #(.W(32), .D(MID)) u_dly_rsum (
		.clk (clk), .en (en), .din (rsum_s1), .dout (rsum_m1)
	);

	// penetration depth, never negative on a hit
	logic [32:0] pen_s22;
	logic [32:0] dist_s22;

	always_ff @(posedge clk) begin
		if (en) begin
			pen_s22  <= {1'b0, rsum_m1} - dist_s21;
			dist_s22 <= dist_s21;
		end
	end

	logic [98:0] dmag_d;

	ssc_delay #(.W(99), .D(MID)) u_dly_dmag (
		.clk  (clk),
		.en   (en),
		.din  ({dmag_s2[2], dmag_s2[1], dmag_s2[0]}),
		.dout (dmag_d)
	);

	// normal numerators |d| * pen
	logic [NN_W-1:0] prod_s23 [3];
	logic [32:0]     dist_s23;
	logic [65:0]     prod_full [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_full[i] = {33'd0, dmag_d[33*i +: 33]} * {33'd0, pen_s22};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) prod_s23[i] <= prod_full[i][NN_W-1:0];
			dist_s23 <= dist_s22;
		end
	end

	// normal dividers by the rounded distance
	logic [NQ_W-1:0] nq_e  [3];
	logic [ND_W-1:0] nr_e  [3];
	logic [ND_W-1:0] ndv_e [3];

	for (genvar i = 0; i < 3; i++) begin : g_ndiv
		ssc_div #(.N(NN_W), .Q(NQ_W), .W(ND_W), .STEPS(STEPS)) u_div (
			.clk      (clk),
			.en       (en),
			.dividend (prod_s23[i]),
			.divisor  (dist_s23),
			.quot     (nq_e[i]),
			.rem      (nr_e[i]),
			.dv       (ndv_e[i])
		);
	end

	// side data aligned to the normal quotients
	logic [2:0]  dneg_e;
	logic [1:0]  flag_e;
	logic [95:0] ct_e;

	ssc_delay #(.W(3), .D(ENDQ - 2)) u_dly_dneg (
		.clk (clk), .en (en), .din (dneg_s2), .dout (dneg_e)
	);

	ssc_delay #(.W(2), .D(ENDQ - 5)) u_dly_flag (
		.clk (clk), .en (en), .din ({coin_s5, hit_s5}), .dout (flag_e)
	);

	ssc_delay #(.W(96), .D(ENDQ - MID - 1)) u_dly_ct (
		.clk  (clk),
		.en   (en),
		.din  ({ct_s21[2], ct_s21[1], ct_s21[0]}),
		.dout (ct_e)
	);

	// output register: everything zero without a hit, normal zero on coincident centers
	logic        hit_q;
	logic        coin_q;
	logic [31:0] contact_q [3];
	logic [31:0] normal_q  [3];

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= flag_e[0];
			coin_q <= flag_e[0] && flag_e[1];
			for (int i = 0; i < 3; i++) begin
				contact_q[i] <= flag_e[0] ? ct_e[32*i +: 32] : 32'd0;
				normal_q[i]  <= (flag_e[0] && !flag_e[1]) ?
					round_sat(dneg_e[i], nq_e[i], nr_e[i], ndv_e[i]) : 32'd0;
			end
		end
	end

	assign m_axis_tdata = {normal_q[2], normal_q[1], normal_q[0],
		contact_q[2], contact_q[1], contact_q[0]};
	assign m_axis_tuser = {coin_q, hit_q};

	// coincident centers are only reported on a hit
	a_coin_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
		else $error("coincident without hit");

	// a miss carries an all-zero payload
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("nonzero payload on a miss");

	// coincident centers give a zero normal
	a_coin_normal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[191:96] == '0)
		else $error("nonzero normal with coincident centers");

	// an accepted transaction enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_q[0])
		else $error("accepted transaction lost at pipe entry");

endmodule

[rtl/ssc_delay.sv]
`timescale 1ns / 1ps
// enabled shift line that keeps side data aligned with the arithmetic stages
// depends on ssc_pkg
module ssc_delay
	import ssc_pkg::*;
#(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int k = 1; k < D; k++) tap_q[k] <= tap_q[k-1];
		end
	end

	assign dout = tap_q[D-1];

endmodule

[rtl/ssc_sqrt.sv]
`timescale 1ns / 1ps
// pipelined digit-by-digit integer square root, STEPS root bits per stage
// depends on ssc_pkg
module ssc_sqrt
	import ssc_pkg::*;
#(
	parameter int STEPS = STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [SQ_IN_W-1:0]   radicand,
	output logic [SQ_ROOT_W-1:0] root,
	output logic [SQ_REM_W-1:0]  rem
);

	localparam int NST = (SQ_ROOT_W + STEPS - 1) / STEPS;

	logic [SQ_IN_W-1:0]   x_s    [NST];
	logic [SQ_ROOT_W-1:0] root_s [NST];
	logic [SQ_REM_W-1:0]  rem_s  [NST];

	logic [SQ_IN_W-1:0]   x_in    [NST];
	logic [SQ_ROOT_W-1:0] root_in [NST];
	logic [SQ_REM_W-1:0]  rem_in  [NST];

	assign x_in[0]    = radicand;
	assign root_in[0] = '0;
	assign rem_in[0]  = '0;

	for (genvar k = 1; k < NST; k++) begin : g_link
		assign x_in[k]    = x_s[k-1];
		assign root_in[k] = root_s[k-1];
		assign rem_in[k]  = rem_s[k-1];
	end

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic [SQ_IN_W-1:0]   x_n;
		logic [SQ_ROOT_W-1:0] root_n;
		logic [SQ_REM_W-1:0]  rem_n;

		always_comb begin
			logic [SQ_REM_W+1:0] t;
			logic [SQ_REM_W+1:0] trial;
			x_n    = x_in[k];
			root_n = root_in[k];
			rem_n  = rem_in[k];
			t      = '0;
			trial  = '0;
			for (int j = 0; j < STEPS; j++) begin
				if (k * STEPS + j < SQ_ROOT_W) begin
					t     = {rem_n, x_n[SQ_IN_W-1 -: 2]};
					trial = {{(SQ_REM_W - SQ_ROOT_W){1'b0}}, root_n, 2'b01};
					x_n   = {x_n[SQ_IN_W-3:0], 2'b00};
					if (t >= trial) begin
						t      = t - trial;
						root_n = {root_n[SQ_ROOT_W-2:0], 1'b1};
					end else begin
						root_n = {root_n[SQ_ROOT_W-2:0], 1'b0};
					end
					rem_n = t[SQ_REM_W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= x_n;
				root_s[k] <= root_n;
				rem_s[k]  <= rem_n;
			end
		end
	end

	assign root = root_s[NST-1];
	assign rem  = rem_s[NST-1];

endmodule

[rtl/ssc_div.sv]
`timescale 1ns / 1ps
// pipelined restoring divider, STEPS quotient bits per stage, divisor carried along
// depends on ssc_pkg; caller guarantees the quotient fits in Q bits
module ssc_div
	import ssc_pkg::*;
#(
	parameter int N     = CN_W,
	parameter int Q     = CQ_W,
	parameter int W     = CD_W,
	parameter int STEPS = STEPS_DEF
) (
	input  logic         clk,
	input  logic         en,
	input  logic [N-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic [Q-1:0] quot,
	output logic [W-1:0] rem,
	output logic [W-1:0] dv
);

	localparam int NST = (Q + STEPS - 1) / STEPS;

	logic [W-1:0] rem_s [NST];
	logic [Q-1:0] low_s [NST];
	logic [W-1:0] dv_s  [NST];

	logic [W-1:0] rem_in [NST];
	logic [Q-1:0] low_in [NST];
	logic [W-1:0] dv_in  [NST];

	assign rem_in[0] = W'(dividend[N-1:Q]);
	assign low_in[0] = dividend[Q-1:0];
	assign dv_in[0]  = divisor;

	for (genvar k = 1; k < NST; k++) begin : g_link
		assign rem_in[k] = rem_s[k-1];
		assign low_in[k] = low_s[k-1];
		assign dv_in[k]  = dv_s[k-1];
	end

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic [W-1:0] rem_n;
		logic [Q-1:0] low_n;

		always_comb begin
			logic [W:0] t;
			rem_n = rem_in[k];
			low_n = low_in[k];
			t     = '0;
			for (int j = 0; j < STEPS; j++) begin
				if (k * STEPS + j < Q) begin
					t = {rem_n, low_n[Q-1]};
					if (t >= {1'b0, dv_in[k]}) begin
						t     = t - {1'b0, dv_in[k]};
						low_n = {low_n[Q-2:0], 1'b1};
					end else begin
						low_n = {low_n[Q-2:0], 1'b0};
					end
					rem_n = t[W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_n;
				low_s[k] <= low_n;
				dv_s[k]  <= dv_in[k];
			end
		end
	end

	assign quot = low_s[NST-1];
	assign rem  = rem_s[NST-1];
	assign dv   = dv_s[NST-1];

endmodule
